[rtl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the alphabet lookup for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned StoreW  = 3 * SextetW;
  localparam int unsigned GroupW  = 4 * SextetW;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [CharW-1:0] out_byte;
    logic             last;
    logic             no_data;
  } out_beat_t;

  // One decoded group waiting to be emitted: nbytes is 1..3.
  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [1:0]        nbytes;
    logic              last;
    logic              no_data;
  } job_t;

  typedef struct packed {
    logic               valid;
    logic [SextetW-1:0] value;
  } sextet_t;

  function automatic sextet_t map_char(logic [CharW-1:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = '0;
    case (c) inside
      [8'h41:8'h5a]: s.value = SextetW'(c - 8'h41);
      [8'h61:8'h7a]: s.value = SextetW'(c - 8'h47);
      [8'h30:8'h39]: s.value = SextetW'(c + 8'h04);
      8'h2b:         s.value = SextetW'(62);
      8'h2f:         s.value = SextetW'(63);
      default:       s.valid = 1'b0;
    endcase
    return s;
  endfunction

endpackage

[rtl/b64d_front.sv]
// ----------------------------------------------------------------------------
// b64d_front
// Maps text bytes to sextets, gathers groups and issues decode jobs.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_data_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);

  logic [StoreW-1:0] store_q, store_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [StoreW-1:0] store_n;
  logic [1:0]        cnt_n;
  logic              accept;
  logic              gen;
  sextet_t           sx;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i & job_ready_i;
  assign job_valid_o = accept & gen;

  always_comb begin
    sx      = map_char(in_data_i.char_in);
    gen     = 1'b0;
    job_o   = '0;
    store_n = store_q;
    cnt_n   = cnt_q;
    store_d = store_q;
    cnt_d   = cnt_q;
    if (sx.valid && cnt_q == 2'd3) begin
      gen          = 1'b1;
      job_o.group  = {store_q, sx.value};
      job_o.nbytes = 2'd3;
      job_o.last   = in_data_i.end_of_text;
      store_d      = '0;
      cnt_d        = '0;
    end else begin
      if (sx.valid) begin
        store_n = {store_q[StoreW-SextetW-1:0], sx.value};
        cnt_n   = cnt_q + 2'd1;
      end
      store_d = store_n;
      cnt_d   = cnt_n;
      if (in_data_i.end_of_text) begin
        gen        = 1'b1;
        job_o.last = 1'b1;
        if (cnt_n == 2'd3) begin
          job_o.group  = {store_n, {SextetW{1'b0}}};
          job_o.nbytes = 2'd2;
        end else if (cnt_n == 2'd2) begin
          job_o.group  = {store_n[2*SextetW-1:0], {(2*SextetW){1'b0}}};
          job_o.nbytes = 2'd1;
        end else begin
          job_o.nbytes  = 2'd1;
          job_o.no_data = 1'b1;
        end
        store_d = '0;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      store_q <= store_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/b64d_queue.sv]
// ----------------------------------------------------------------------------
// b64d_queue
// Small register FIFO of decode jobs between front and back.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic ready_o,
  input  job_t data_i,
  output logic valid_o,
  input  logic pop_i,
  output job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= next_ptr(wr_q);
      end
      if (do_pop) begin
        rd_q <= next_ptr(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/b64d_back.sv]
// ----------------------------------------------------------------------------
// b64d_back
// Emits job bytes via an output register, one beat per cycle when not stalled.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_pop_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic      out_valid_q;
  out_beat_t out_q, out_d;
  logic [1:0] idx_q;
  logic      load;
  logic      final_byte;

  assign load       = job_valid_i & (~out_valid_q | out_ready_i);
  assign final_byte = (idx_q == job_i.nbytes - 2'd1);
  assign job_pop_o  = load & final_byte;

  always_comb begin
    out_d.last    = job_i.last & final_byte;
    out_d.no_data = job_i.no_data;
    case (idx_q)
      2'd0:    out_d.out_byte = job_i.group[GroupW-1 -: CharW];
      2'd1:    out_d.out_byte = job_i.group[GroupW-CharW-1 -: CharW];
      default: out_d.out_byte = job_i.group[CharW-1:0];
    endcase
    if (job_i.no_data) begin
      out_d.out_byte = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= final_byte ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/base64_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 text decoder, one text byte per input beat.
// ----------------------------------------------------------------------------
// Accepts one text byte per cycle while the job queue has room, and emits at
// most one decoded byte per cycle. Bytes outside the standard alphabet, '='
// included, are dropped; each group of four sextets gives three bytes, and the
// byte flagged end_of_text flushes a partial group (k sextets give k-1 bytes)
// or, if that leaves no byte, one beat with no_data and last set. A result
// passes through the job queue and then the output register. The output port,
// which drains one byte per cycle when not stalled, sets the rate; the job
// queue (QueueDepth entries) lets input continue while a group of three bytes
// drains, so ordinary text sustains one input beat per cycle if not stalled.
module base64_stream_decoder_unit import b64d_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic job_push, job_ready, job_valid, job_pop;
  job_t job_in, job_out;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_push),
    .job_ready_i (job_ready),
    .job_o       (job_in)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .ready_o (job_ready),
    .data_i  (job_in),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .data_o  (job_out)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job_out),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/b64d_checker.sv]
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder output channel.
// ----------------------------------------------------------------------------
module b64d_checker import b64d_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_nodata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_data |-> out_data_o.last && out_data_o.out_byte == '0)
    else $error("empty end marker without last or with nonzero byte");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind base64_stream_decoder_unit b64d_checker u_chk (.*);

[dv/tb_base64_stream_decoder_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder_unit
// Self-checking testbench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// Text bytes go in one beat at a time, and decoded bytes come back one beat at
// a time. A tracker class mirrors the decoder and keeps a queue of the beats it
// predicts. Each output beat is checked against the oldest one in that queue.
// The run starts with directed texts: alphabet edges, full groups, partial
// groups and empty ends. Random texts with noise bytes follow, under four
// flow-control phases: no idling, sender idle, receiver stall, and both.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_unit;
  import b64d_pkg::*;

  class decode_tracker;
    logic [17:0] sextets;
    int unsigned held;
    out_beat_t   due_beats[$];
    int unsigned mismatches;

    function new();
      sextets    = '0;
      held       = 0;
      mismatches = 0;
    endfunction

    function bit sextet_of(input logic [7:0] c, output logic [5:0] v);
      v = '0;
      if (c >= "A" && c <= "Z") v = 6'(c - "A");
      else if (c >= "a" && c <= "z") v = 6'(c - "a" + 8'd26);
      else if (c >= "0" && c <= "9") v = 6'(c - "0" + 8'd52);
      else if (c == "+") v = 6'd62;
      else if (c == "/") v = 6'd63;
      else return 1'b0;
      return 1'b1;
    endfunction

    function void push(input logic [7:0] data, input logic lst, input logic nd);
      out_beat_t o;
      o.out_byte = data;
      o.last     = lst;
      o.no_data  = nd;
      due_beats.push_back(o);
    endfunction

    function void take_char(input in_beat_t b);
      logic [5:0]  v;
      logic [23:0] grp;
      bit          flushed;
      flushed = 1'b0;
      if (sextet_of(b.char_in, v)) begin
        if (held == 3) begin
          grp = {sextets, v};
          push(grp[23:16], 1'b0, 1'b0);
          push(grp[15:8], 1'b0, 1'b0);
          push(grp[7:0], b.end_of_text, 1'b0);
          sextets = '0;
          held    = 0;
          flushed = 1'b1;
        end else begin
          sextets = {sextets[11:0], v};
          held++;
        end
      end
      if (b.end_of_text) begin
        if (!flushed) begin
          if (held == 2) begin
            push(sextets[11:4], 1'b1, 1'b0);
          end else if (held == 3) begin
            grp = {sextets, 6'd0};
            push(grp[23:16], 1'b0, 1'b0);
            push(grp[15:8], 1'b1, 1'b0);
          end else begin
            push(8'h00, 1'b1, 1'b1);
          end
        end
        sextets = '0;
        held    = 0;
      end
    endfunction

    function void check_byte(input out_beat_t got);
      out_beat_t want;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat: byte %h last %b no_data %b", $time,
                   got.out_byte, got.last, got.no_data);
        return;
      end
      want = due_beats.pop_front();
      // out_byte carries nothing on a no_data beat
      if (got.last !== want.last || got.no_data !== want.no_data ||
          (!want.no_data && got.out_byte !== want.out_byte)) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch: expected byte %h last %b no_data %b, ",
                    "got byte %h last %b no_data %b"},
                   $time, want.out_byte, want.last, want.no_data,
                   got.out_byte, got.last, got.no_data);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  decode_tracker tracker = new();
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   counted;
  string         alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  int unsigned   idle_tbl[4]  = '{0, 69, 0, 31};
  int unsigned   stall_tbl[4] = '{0, 0, 69, 31};

  base64_stream_decoder_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_base64_stream_decoder_unit: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // handshake signals only change at the rising edge, so the falling edge
  // shows what the next rising edge will accept
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_byte(out_data_o);
  end

  task automatic send_beat(input logic [7:0] c, input logic eot);
    in_beat_t   b;
    logic [5:0] v;
    b.char_in     = c;
    b.end_of_text = eot;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    tracker.take_char(b);
    if (eot || tracker.sextet_of(c, v)) counted++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.due_beats.size() != 0);
  endtask

  task automatic run_directed();
    send_beat("T", 1'b0); send_beat("W", 1'b0);
    send_beat("F", 1'b0); send_beat("u", 1'b1);
    send_beat("A", 1'b0); send_beat("Z", 1'b0);
    send_beat("a", 1'b0); send_beat("z", 1'b0);
    send_beat("0", 1'b0); send_beat("9", 1'b0);
    send_beat("+", 1'b0); send_beat("/", 1'b1);
    send_beat(8'h00, 1'b0); send_beat(8'hff, 1'b0);
    send_beat("[", 1'b0); send_beat("Q", 1'b0);
    send_beat("Q", 1'b0); send_beat("=", 1'b1);
    send_beat("T", 1'b0); send_beat("W", 1'b0);
    send_beat("E", 1'b0); send_beat("=", 1'b1);
    send_beat("T", 1'b1);
    send_beat(8'h60, 1'b1);
  endtask

  task automatic send_text();
    int unsigned n;
    int unsigned endk;
    bit          noisy;
    n     = $urandom_range(9);
    noisy = ($urandom_range(3) == 0);
    endk  = $urandom_range(3);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(2) == 0) send_beat(8'($urandom_range(255)), 1'b0);
      send_beat(alphabet[$urandom_range(63)], endk == 0 && i == n - 1);
    end
    if (endk == 1) send_beat("=", 1'b1);
    else if (endk != 0 || n == 0) send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    counted        = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tbl[ph];
      recv_stall_pct = stall_tbl[ph];
      if (ph == 0) run_directed();
      counted = 0;
      while (counted < 50) begin
        send_text();
        if ($urandom_range(7) == 0) wait_drained();
      end
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due_beats.size() == 0) begin
      $display("tb_base64_stream_decoder_unit: PASS");
    end else begin
      $display("tb_base64_stream_decoder_unit: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder_unit.sv
rtl/b64d_checker.sv
dv/tb_base64_stream_decoder_unit.sv
